### hdl/lggc_pkg.sv
// lggc_pkg: shared constants, types and elaboration-time tables for the
// lift/gamma/gain corrector. No dependencies.
`timescale 1ns / 1ps
package lggc_pkg;

	localparam int PIXEL_BITS    = 16;
	localparam int OUT_FRAC_BITS = 16;
	localparam int CFG_DATA_W    = 17;
	localparam int CFG_INDEX_W   = 3;

	localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SCALE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIFT       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAMMA      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ENHANCED   = 3'd4;

	// Q30 one
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	// -log2(1e-8) in Q16
	localparam logic [20:0] NEG_LOG2_TINY = 21'd1741647;
	localparam logic [9:0]  MILLI = 10'd1000;
	// ceil(2^38 / 125): exact floor(x / 125) for x below 2^31
	localparam logic [31:0] RECIP_125 = 32'd2199023256;
	// output code for one
	localparam logic [23:0] CODE_ONE = 24'((64'd1 << OUT_FRAC_BITS) - 64'd1);

	typedef struct packed {
		logic vld;
		logic flag;
	} ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bt;
		rem = v;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			bt = 64'd1 << (2 * i);
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q30, built by repeated truncating square roots from one half
	function automatic logic [29:0] root_val(input int k);
		logic [63:0] r;
		r = 64'd1 << 29;
		for (int i = 1; i <= k; i++) begin
			r = isqrt64(r << 30);
		end
		return r[29:0];
	endfunction

endpackage

### hdl/lggc_if.sv
// lggc interfaces: pixel input channel and corrected result channel.
// Depends on nothing.
`timescale 1ns / 1ps
interface lggc_pix_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_value;
	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface lggc_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] corrected_value;
	logic [15:0] range_low;
	logic [15:0] range_high;
	modport source (output valid, output corrected_value, output range_low,
		output range_high, input ready);
	modport sink (input valid, input corrected_value, input range_low,
		input range_high, output ready);
endinterface

### hdl/lggc_div.sv
// lggc_div: pipelined restoring divider, one quotient bit per stage,
// 64-bit dividend, 33-bit divisor, 32-bit quotient with overflow. Uses lggc_pkg.
`timescale 1ns / 1ps
module lggc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  lggc_pkg::ctl_t      ctl_i,
	input  logic [63:0]         dividend,
	input  logic [32:0]         divisor,
	output lggc_pkg::ctl_t      ctl_o,
	output logic [31:0]         quot,
	output logic                ovf
);
	localparam int NB = 32;

	lggc_pkg::ctl_t ctl_s [0:NB];
	logic [32:0]    rem_s [0:NB];
	logic [31:0]    low_s [0:NB];
	logic [32:0]    dv_s  [0:NB];
	logic [31:0]    q_s   [0:NB];
	logic           ovf_s [0:NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else if (en) ctl_s[0] <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, dividend[63:32]};
			ovf_s[0] <= {1'b0, dividend[63:32]} >= divisor;
			low_s[0] <= dividend[31:0];
			dv_s[0]  <= divisor;
			q_s[0]   <= '0;
		end
	end

	for (genvar j = 1; j <= NB; j++) begin : g_stage
		localparam int B = NB - j;
		logic [33:0] trial;
		logic        ge;
		assign trial = {rem_s[j-1], low_s[j-1][B]};
		assign ge    = trial >= {1'b0, dv_s[j-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[j] <= '0;
			else if (en) ctl_s[j] <= ctl_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= ge ? 33'(trial - {1'b0, dv_s[j-1]}) : trial[32:0];
				q_s[j]   <= q_s[j-1] | (32'(ge) << B);
				low_s[j] <= low_s[j-1];
				dv_s[j]  <= dv_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
			end
		end
	end

	assign ctl_o = ctl_s[NB];
	assign quot  = q_s[NB];
	assign ovf   = ovf_s[NB];
endmodule

### hdl/lggc_log.sv
// lggc_log: pipelined -log2 of a Q30 value in (0,1], Q16 result.
// Five normalize stages, sixteen squaring stages. Uses lggc_pkg.
`timescale 1ns / 1ps
module lggc_log (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  lggc_pkg::ctl_t ctl_i,
	input  logic [30:0]    y,
	output lggc_pkg::ctl_t ctl_o,
	output logic [20:0]    n
);
	localparam int NS = 21;

	lggc_pkg::ctl_t ctl_s  [0:NS];
	logic [30:0]    m_s    [0:NS];
	logic [4:0]     cnt_s  [0:NS];
	logic [15:0]    frac_s [0:NS];
	lggc_pkg::ctl_t ctl_q;
	logic [20:0]    n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else if (en) ctl_s[0] <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= y;
			cnt_s[0]  <= '0;
			frac_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= NS; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[i] <= '0;
			else if (en) ctl_s[i] <= ctl_s[i-1];
		end

		if (i <= 5) begin : g_norm
			localparam int S = 32 >> i;
			logic zero;
			assign zero = (m_s[i-1][30 -: S] == '0);
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[i]    <= zero ? (m_s[i-1] << S) : m_s[i-1];
					cnt_s[i]  <= zero ? 5'(cnt_s[i-1] + 5'(S)) : cnt_s[i-1];
					frac_s[i] <= frac_s[i-1];
				end
			end
		end else begin : g_sq
			logic [61:0] p;
			assign p = 62'(m_s[i-1]) * 62'(m_s[i-1]);
			always_ff @(posedge clk) begin
				if (en) begin
					m_s[i]    <= p[61] ? p[61:31] : p[60:30];
					frac_s[i] <= {frac_s[i-1][14:0], p[61]};
					cnt_s[i]  <= cnt_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (en) ctl_q <= ctl_s[NS];
	end

	always_ff @(posedge clk) begin
		if (en) n_q <= {cnt_s[NS], 16'd0} - 21'(frac_s[NS]);
	end

	assign ctl_o = ctl_q;
	assign n     = n_q;
endmodule

### hdl/lggc_exp.sv
// lggc_exp: pipelined 2^-e, e in Q16, Q30 result; one root-table product
// per fraction bit, then the integer shift. Uses lggc_pkg.
`timescale 1ns / 1ps
module lggc_exp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  lggc_pkg::ctl_t ctl_i,
	input  logic [31:0]    e,
	output lggc_pkg::ctl_t ctl_o,
	output logic [30:0]    r
);
	localparam int NK = 16;

	lggc_pkg::ctl_t ctl_s [0:NK];
	logic [30:0]    r_s   [0:NK];
	logic [15:0]    fr_s  [0:NK];
	logic [4:0]     sh_s  [0:NK];
	logic           big_s [0:NK];
	lggc_pkg::ctl_t ctl_q;
	logic [30:0]    r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else if (en) ctl_s[0] <= ctl_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]   <= lggc_pkg::Q30_ONE;
			fr_s[0]  <= e[15:0];
			sh_s[0]  <= e[20:16];
			big_s[0] <= e[31:16] > 16'd30;
		end
	end

	for (genvar k = 1; k <= NK; k++) begin : g_stage
		localparam logic [29:0] RK = lggc_pkg::root_val(k);
		logic [60:0] p;
		assign p = 61'(r_s[k-1]) * 61'(RK);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[k] <= '0;
			else if (en) ctl_s[k] <= ctl_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k]   <= fr_s[k-1][NK-k] ? p[60:30] : r_s[k-1];
				fr_s[k]  <= fr_s[k-1];
				sh_s[k]  <= sh_s[k-1];
				big_s[k] <= big_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_q <= '0;
		else if (en) ctl_q <= ctl_s[NK];
	end

	always_ff @(posedge clk) begin
		if (en) r_q <= big_s[NK] ? '0 : (r_s[NK] >> sh_s[NK]);
	end

	assign ctl_o = ctl_q;
	assign r     = r_q;
endmodule

### hdl/lggc_bounds.sv
// lggc_bounds: free-running computation of the output bounds from the
// configuration registers. Uses lggc_pkg, lggc_div, lggc_exp.
`timescale 1ns / 1ps
module lggc_bounds (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] lift,
	input  logic [15:0]        gain,
	input  logic [12:0]        gamma,
	input  logic               enh,
	output logic [30:0]        lo,
	output logic [30:0]        hi
);
	localparam lggc_pkg::ctl_t RUN = '{vld: 1'b1, flag: 1'b0};

	logic signed [17:0] lift_x;
	logic signed [17:0] d;
	logic signed [17:0] nn;
	logic               dpos;
	logic               npos;
	logic [32:0]        dvs;
	logic [33:0]        prod_q;
	logic [62:0]        kprod;
	logic [31:0]        ek;
	logic [30:0]        pw;
	logic signed [33:0] lnum_q;
	logic               lpos;
	logic [31:0]        hq;
	logic               hovf;
	logic [31:0]        lq;
	logic               lovf;
	logic [30:0]        lo_q;
	logic [30:0]        hi_q;

	assign lift_x = $signed({{2{lift[15]}}, lift});
	assign d      = $signed({2'b00, gain}) - lift_x;
	assign nn     = 18'sd16384 - lift_x;
	assign dpos   = d > 0;
	assign npos   = nn > 0;
	assign dvs    = dpos ? {16'd0, d[16:0]} : 33'd1;
	assign lpos   = lnum_q > 0;

	// tiny^gamma = 2^-(NEG_LOG2_TINY * gamma / 1000); /1000 is >>3 then /125
	assign kprod = 63'(prod_q[33:3]) * 63'(lggc_pkg::RECIP_125);

	always_ff @(posedge clk) begin
		prod_q <= 34'(lggc_pkg::NEG_LOG2_TINY) * 34'(gamma);
		ek     <= {7'd0, kprod[62:38]};
		lnum_q <= $signed({3'b000, pw}) - $signed({{2{lift[15]}}, lift, 16'd0});
	end

	lggc_exp u_exp_k (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .ctl_i(RUN),
		.e(ek), .ctl_o(), .r(pw)
	);

	lggc_div u_div_h (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .ctl_i(RUN),
		.dividend(npos ? {17'd0, nn[16:0], 30'd0} : 64'd0), .divisor(dvs),
		.ctl_o(), .quot(hq), .ovf(hovf)
	);

	lggc_div u_div_l (
		.clk(clk), .arst_n(arst_n), .en(1'b1), .ctl_i(RUN),
		.dividend(lpos ? {18'd0, lnum_q[31:0], 14'd0} : 64'd0), .divisor(dvs),
		.ctl_o(), .quot(lq), .ovf(lovf)
	);

	always_ff @(posedge clk) begin
		if (enh && dpos && !hovf && (hq < 32'(lggc_pkg::Q30_ONE))) hi_q <= hq[30:0];
		else hi_q <= lggc_pkg::Q30_ONE;
		if (enh && dpos && lpos) begin
			if (lovf || (lq > 32'(lggc_pkg::Q30_ONE))) lo_q <= lggc_pkg::Q30_ONE;
			else lo_q <= lq[30:0];
		end else begin
			lo_q <= '0;
		end
	end

	assign lo = lo_q;
	assign hi = hi_q;
endmodule

### hdl/lift_gamma_gain_correct.sv
// Lift/gamma/gain corrector: one pixel item in, one corrected item out.
// One item per cycle sustained while the output queue has room, set by the three
// 33-stage dividers and the log/exp pipelines, all fully pipelined.
// A 2-entry output queue decouples the sides; the pipeline holds when it is full.
// Reset (async, active low) clears valid bits and loads config defaults; the
// bounds logic runs freely and settles ahead of any item.
`timescale 1ns / 1ps
module lift_gamma_gain_correct (
	input  logic                               clk,
	input  logic                               arst_n,
	lggc_pix_if.sink                           src,
	lggc_res_if.source                         dst,
	input  logic                               cfg_we,
	input  logic [lggc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [lggc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	// configuration registers
	logic [16:0]        fs_q;
	logic signed [15:0] lift_q;
	logic [15:0]        gain_q;
	logic [12:0]        gamma_q;
	logic               enh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q    <= 17'd65535;
			lift_q  <= '0;
			gain_q  <= 16'd16384;
			gamma_q <= 13'd1000;
			enh_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lggc_pkg::CFG_FULL_SCALE: fs_q    <= cfg_data;
				lggc_pkg::CFG_LIFT:       lift_q  <= $signed(cfg_data[15:0]);
				lggc_pkg::CFG_GAIN:       gain_q  <= cfg_data[15:0];
				lggc_pkg::CFG_GAMMA:      gamma_q <= cfg_data[12:0];
				lggc_pkg::CFG_ENHANCED:   enh_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero full scale / gamma act as one
	logic [16:0]        fs0;
	logic [12:0]        gm0;
	logic signed [17:0] d_w;
	logic signed [34:0] lf_q;

	assign fs0 = (fs_q == '0) ? 17'd1 : fs_q;
	assign gm0 = (gamma_q == '0) ? 13'd1 : gamma_q;
	assign d_w = $signed({2'b00, gain_q}) - $signed({{2{lift_q[15]}}, lift_q});

	// lift * full_scale only changes with config
	always_ff @(posedge clk) begin
		lf_q <= 35'(lift_q * $signed({1'b0, fs0}));
	end

	// bounds, Q30
	logic [30:0] lo_b;
	logic [30:0] hi_b;
	logic [15:0] lo_code_q;
	logic [15:0] hi_code_q;

	lggc_bounds u_bounds (
		.clk(clk), .arst_n(arst_n), .lift(lift_q), .gain(gain_q),
		.gamma(gm0), .enh(enh_q), .lo(lo_b), .hi(hi_b)
	);

	function automatic logic [15:0] to_code(input logic [30:0] v);
		logic [55:0] acc;
		acc = 56'(v) * 56'(lggc_pkg::CODE_ONE) + 56'h2000_0000;
		return acc[45:30];
	endfunction

	always_ff @(posedge clk) begin
		lo_code_q <= to_code(lo_b);
		hi_code_q <= to_code(hi_b);
	end

	// pipeline advance: held only when the output queue is full
	logic [1:0] cnt_q;
	logic       en;
	assign en        = (cnt_q != 2'd2);
	assign src.ready = en;

	// s1: capture pixel
	logic        v_s1;
	logic [15:0] pix_s1;
	// s2: numerator pixel*(gain-lift) + lift*fs
	logic               v_s2;
	logic signed [35:0] num_s2;
	logic               num_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= src.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= 16'(src.pixel_value[lggc_pkg::PIXEL_BITS-1:0]);
			num_s2 <= $signed({1'b0, pix_s1}) * d_w + lf_q;
		end
	end

	assign num_pos = num_s2 > 0;

	// y = num * 2^16 / fs ; flag marks a zero base
	lggc_pkg::ctl_t c_a;
	logic [31:0]    q_a;
	logic           ovf_a;

	lggc_div u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.ctl_i('{vld: v_s2, flag: !num_pos}),
		.dividend(num_pos ? {14'd0, num_s2[33:0], 16'd0} : 64'd0),
		.divisor(33'(fs0)), .ctl_o(c_a), .quot(q_a), .ovf(ovf_a)
	);

	// s3: cap y at one; a zero base (also a quotient that truncates to zero)
	// takes a dummy nonzero value and is flagged
	lggc_pkg::ctl_t c_s3;
	logic [30:0]    y_s3;
	logic           y_zero;

	assign y_zero = c_a.flag || (!ovf_a && (q_a == '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s3 <= '0;
		else if (en) c_s3 <= '{vld: c_a.vld, flag: y_zero};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_zero) y_s3 <= 31'd1;
			else if (ovf_a || (q_a > 32'(lggc_pkg::Q30_ONE))) y_s3 <= lggc_pkg::Q30_ONE;
			else y_s3 <= q_a[30:0];
		end
	end

	lggc_pkg::ctl_t c_l;
	logic [20:0]    n_l;

	lggc_log u_log (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(c_s3), .y(y_s3),
		.ctl_o(c_l), .n(n_l)
	);

	// s4: scale the log by 1000 before dividing by gamma
	lggc_pkg::ctl_t c_s4;
	logic [30:0]    t_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s4 <= '0;
		else if (en) c_s4 <= c_l;
	end

	always_ff @(posedge clk) begin
		if (en) t_s4 <= 31'(n_l * lggc_pkg::MILLI);
	end

	lggc_pkg::ctl_t c_b;
	logic [31:0]    e_b;

	lggc_div u_div_g (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(c_s4),
		.dividend({33'd0, t_s4}), .divisor(33'(gm0)),
		.ctl_o(c_b), .quot(e_b), .ovf()
	);

	lggc_pkg::ctl_t c_e;
	logic [30:0]    r_e;

	lggc_exp u_exp (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(c_b), .e(e_b),
		.ctl_o(c_e), .r(r_e)
	);

	// s5: clamp to bounds; flag now marks an empty range
	logic [30:0]    qz;
	logic [30:0]    qh;
	logic [30:0]    ql;
	logic           empty;
	lggc_pkg::ctl_t c_s5;
	logic [30:0]    delta_s5;

	assign qz    = c_e.flag ? 31'd0 : r_e;
	assign qh    = (qz > hi_b) ? hi_b : qz;
	assign ql    = (qh < lo_b) ? lo_b : qh;
	assign empty = !(hi_b > lo_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) c_s5 <= '0;
		else if (en) c_s5 <= '{vld: c_e.vld, flag: empty};
	end

	always_ff @(posedge clk) begin
		if (en) delta_s5 <= ql - lo_b;
	end

	lggc_pkg::ctl_t c_c;
	logic [31:0]    s_c;

	lggc_div u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .ctl_i(c_s5),
		.dividend({3'd0, delta_s5, 30'd0}),
		.divisor(empty ? 33'd1 : 33'(hi_b - lo_b)),
		.ctl_o(c_c), .quot(s_c), .ovf()
	);

	// s6: stretched value, s7: output code
	logic        v_s6;
	logic [30:0] s_s6;
	logic        v_s7;
	logic [15:0] code_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s6 <= c_c.vld;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s6    <= c_c.flag ? 31'd0 : s_c[30:0];
			code_s7 <= to_code(s_s6);
		end
	end

	// output queue, two items
	logic [47:0] fifo_q [0:1];
	logic        wr_q;
	logic        rd_q;
	logic        push;
	logic        pop;

	assign push = en && v_s7;
	assign pop  = dst.valid && dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= 2'(cnt_q + 2'(push) - 2'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= {code_s7, lo_code_q, hi_code_q};
	end

	assign dst.valid           = (cnt_q != 2'd0);
	assign dst.corrected_value = fifo_q[rd_q][47:32];
	assign dst.range_low       = fifo_q[rd_q][31:16];
	assign dst.range_high      = fifo_q[rd_q][15:0];
endmodule

### sim/tb_lift_gamma_gain_correct.sv
// Testbench for lift_gamma_gain_correct: directed table, then random pixel streams
// under random configurations, checked by a bit-exact predictor or the typed row.
// Depends on hdl/lggc_pkg.sv, hdl/lggc_if.sv and hdl/lift_gamma_gain_correct.sv.
`timescale 1ns / 1ps
module tb_lift_gamma_gain_correct;

	localparam int STALL_LIMIT = 20000;  // cycles with no item accepted on either side
	localparam int SETTLE      = 150;    // lets the bounds logic settle
	localparam int DRAIN       = 200;    // lets the pipeline drain
	localparam int RAND_ITEMS  = 1780;

	typedef struct packed {
		logic [15:0] corrected_value;
		logic [15:0] range_low;
		logic [15:0] range_high;
	} result_t;

	// one row of the directed table: either a register write or a pixel item
	typedef struct packed {
		logic                             is_cfg;
		logic [lggc_pkg::CFG_INDEX_W-1:0] idx;
		logic [lggc_pkg::CFG_DATA_W-1:0]  data;
		logic [15:0]                      pix;
		logic                             typed;   // expected result given in the row
		result_t                          res;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [lggc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [lggc_pkg::CFG_DATA_W-1:0]  cfg_data;

	lggc_pix_if src ();
	lggc_res_if dst ();

	lift_gamma_gain_correct i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (src),
		.dst       (dst),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block's registers, updated on each write
	logic [16:0] sh_full_scale;
	logic [15:0] sh_lift;
	logic [15:0] sh_gain;
	logic [12:0] sh_gamma;
	logic        sh_enhanced;

	logic [63:0] half_roots [0:16];   // 2^(-2^-k) in Q30
	result_t     pending_results [$];
	int          errors;
	int          idle_cycles;
	bit          src_calm;
	bit          dst_calm;
	int          dst_stall;

	// the typed expectation travels with the item it belongs to
	logic    item_typed;
	result_t item_res;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] acc, b, r;
		r   = v;
		acc = '0;
		b   = 64'd1 << 62;
		while (b > r) b = b >> 2;
		while (b != 0) begin
			if (r >= acc + b) begin
				r   = r - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return acc;
	endfunction

	// -log2(y / 2^30) in Q16 for y in (0, 2^30]; fraction by repeated squaring
	function automatic logic [63:0] neg_log2(input logic [63:0] y);
		int          msb;
		logic [63:0] m, frac;
		msb  = 30;
		frac = '0;
		while (msb > 0 && y[msb] == 1'b0) msb--;
		m = y << (30 - msb);
		for (int i = 0; i < 16; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m       = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return 64'(30 - msb) * 64'd65536 - frac;
	endfunction

	// 2^-e in Q30, e in Q16
	function automatic logic [63:0] exp2_neg(input logic [63:0] e);
		logic [63:0] r;
		r = 64'd1 << 30;
		if ((e >> 16) > 30) return '0;
		for (int k = 1; k <= 16; k++)
			if (e[16-k]) r = (r * half_roots[k]) >> 30;
		return r >> (e >> 16);
	endfunction

	function automatic logic [15:0] q30_to_code(input logic [63:0] v);
		logic [63:0] full;
		full = (64'd1 << lggc_pkg::OUT_FRAC_BITS) - 64'd1;
		return 16'((v * full + (64'd1 << 29)) >> 30);
	endfunction

	function automatic result_t correct_pixel(input logic [15:0] pixel);
		longint      pix, fs, lift, d, num, den_hi, lnum;
		logic [63:0] gm, y, q, lo, hi, h, pw, l, s;
		result_t     r;
		pix  = longint'(pixel);
		fs   = (sh_full_scale == 0) ? 1 : longint'(sh_full_scale);
		lift = longint'($signed(sh_lift));
		d    = longint'(sh_gain) - lift;
		gm   = (sh_gamma == 0) ? 64'd1 : 64'(sh_gamma);
		num  = pix * d + lift * fs;
		lo   = '0;
		hi   = 64'd1 << 30;
		if (num <= 0) begin
			y = '0;
		end else begin
			y = (64'(num) << 16) / 64'(fs);
			if (y > (64'd1 << 30)) y = 64'd1 << 30;
		end
		q = (y == 0) ? 64'd0 : exp2_neg(neg_log2(y) * 64'd1000 / gm);
		// derived bounds only when gain is strictly above lift
		if (sh_enhanced && d > 0) begin
			den_hi = 16384 - lift;
			h      = (den_hi <= 0) ? 64'd0 : (64'(den_hi) << 30) / 64'(d);
			pw     = exp2_neg(64'(lggc_pkg::NEG_LOG2_TINY) * gm / 64'd1000);
			lnum   = longint'(pw) - lift * 65536;
			if (h < (64'd1 << 30)) hi = h;
			if (lnum > 0) begin
				l  = (64'(lnum) << 14) / 64'(d);
				lo = (l > (64'd1 << 30)) ? (64'd1 << 30) : l;
			end
		end
		if (q > hi) q = hi;
		if (q < lo) q = lo;
		s = (hi > lo) ? ((q - lo) << 30) / (hi - lo) : 64'd0;   // empty range gives zero
		r.corrected_value = q30_to_code(s);
		r.range_low       = q30_to_code(lo);
		r.range_high      = q30_to_code(hi);
		return r;
	endfunction

	// ---------------------------------------------------------------- monitors

	// input side: record the expectation of each accepted item; watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (src.valid && src.ready)
				pending_results.push_back(item_typed ? item_res : correct_pixel(src.pixel_value));
			if ((src.valid && src.ready) || (dst.valid && dst.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// output side: compare each accepted item with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && dst.valid && dst.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result item: corrected_value %0d", dst.corrected_value);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (dst.corrected_value !== want.corrected_value) begin
					$error("corrected_value: expected %0d, got %0d",
						want.corrected_value, dst.corrected_value);
					errors++;
				end
				if (dst.range_low !== want.range_low) begin
					$error("range_low: expected %0d, got %0d", want.range_low, dst.range_low);
					errors++;
				end
				if (dst.range_high !== want.range_high) begin
					$error("range_high: expected %0d, got %0d", want.range_high, dst.range_high);
					errors++;
				end
			end
		end
	end

	// receiver stalls: mostly short, a few long; none at all in calm phases
	always @(posedge clk) begin
		if (dst_stall > 0) begin
			dst.ready <= 1'b0;
			dst_stall <= dst_stall - 1;
		end else begin
			dst.ready <= 1'b1;
			if (!dst_calm && $urandom_range(0, 3) == 0)
				dst_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
					: $urandom_range(1, 3);
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic int pick_gap();
		if (src_calm || $urandom_range(0, 2) != 0) return 0;
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
	endfunction

	// one pixel item; valid stays high into the next item when no gap follows
	task automatic send_pixel(input logic [15:0] pix, input logic typed, input result_t res);
		int gap;
		gap = pick_gap();
		src.valid       <= 1'b1;
		src.pixel_value <= pix;
		item_typed      <= typed;
		item_res        <= res;
		@(posedge clk);
		while (!src.ready) @(posedge clk);
		if (gap > 0) begin
			src.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register writes only with the block empty
	task automatic write_reg(input logic [lggc_pkg::CFG_INDEX_W-1:0] idx,
		input logic [lggc_pkg::CFG_DATA_W-1:0] data);
		src.valid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			lggc_pkg::CFG_FULL_SCALE: sh_full_scale = data[16:0];
			lggc_pkg::CFG_LIFT:       sh_lift       = data[15:0];
			lggc_pkg::CFG_GAIN:       sh_gain       = data[15:0];
			lggc_pkg::CFG_GAMMA:      sh_gamma      = data[12:0];
			lggc_pkg::CFG_ENHANCED:   sh_enhanced   = data[0];
			default: ;
		endcase
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [16:0] rand_full_scale();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd65536;
			3: return 17'h1FFFF;
			4: return 17'($urandom());
			default: return 17'($urandom_range(1, 65536));
		endcase
	endfunction

	function automatic logic [16:0] rand_lift();
		case ($urandom_range(0, 7))
			0: return 17'(16'(-16384));
			1: return 17'd16384;
			2: return 17'(16'($urandom()));
			default: return 17'(16'($urandom_range(0, 32768) - 16384));
		endcase
	endfunction

	function automatic logic [16:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd32768;
			2: return 17'(16'($urandom()));
			default: return 17'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [16:0] rand_gamma();
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd1;
			2: return 17'd5000;
			3: return 17'(13'($urandom()));
			default: return 17'($urandom_range(1, 5000));
		endcase
	endfunction

	function automatic logic [15:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom());
		endcase
	endfunction

	localparam result_t NO_RES = '0;

	// directed part: rows with a typed result are at reset defaults (identity)
	localparam int N_ROWS = 34;
	localparam row_t DIRECTED [N_ROWS] = '{
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd0,    1'b1, '{16'd0, 16'd0, 16'd65535}},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'hFFFF, 1'b1,
			'{16'd65535, 16'd0, 16'd65535}},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd1,    1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h8000, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h5555, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'hAAAA, 1'b0, NO_RES},
		// gamma and enhanced bounds with gain above lift
		'{1'b1, lggc_pkg::CFG_GAMMA,      17'd2200,  16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_LIFT,       17'(16'(-3000)), 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_GAIN,       17'd20000, 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_ENHANCED,   17'd1,     16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd0,    1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h4000, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'hFFFF, 1'b0, NO_RES},
		// lift at one: high bound collapses to zero, empty range
		'{1'b1, lggc_pkg::CFG_LIFT,       17'd16384, 16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h1234, 1'b0, NO_RES},
		// lift above one with gain higher still: high bound held at zero
		'{1'b1, lggc_pkg::CFG_GAIN,       17'd40000, 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_LIFT,       17'd20000, 16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd777,  1'b0, NO_RES},
		// gain not above lift: bounds stay zero and one
		'{1'b1, lggc_pkg::CFG_GAIN,       17'd0,     16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'hFFFF, 1'b0, NO_RES},
		// lift at minus one, tiny gain: low bound just below one
		'{1'b1, lggc_pkg::CFG_LIFT,       17'(16'(-16384)), 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_GAIN,       17'd1,     16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_GAMMA,      17'd5000,  16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h9000, 1'b0, NO_RES},
		// zero full scale and zero gamma act as one
		'{1'b1, lggc_pkg::CFG_GAIN,       17'd32768, 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_LIFT,       17'd0,     16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_FULL_SCALE, 17'd0,     16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_GAMMA,      17'd0,     16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd0,    1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'd1,    1'b0, NO_RES},
		// widest full scale
		'{1'b1, lggc_pkg::CFG_FULL_SCALE, 17'h1FFFF, 16'd0, 1'b0, NO_RES},
		'{1'b1, lggc_pkg::CFG_GAMMA,      17'd1,     16'd0, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'hFFFF, 1'b0, NO_RES},
		'{1'b0, lggc_pkg::CFG_FULL_SCALE, 17'd0, 16'h00FF, 1'b0, NO_RES}
	};

	initial begin
		int sent, burst;
		logic [63:0] root;
		src.valid       = 1'b0;
		src.pixel_value = '0;
		dst.ready       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = lggc_pkg::CFG_FULL_SCALE;
		cfg_data        = '0;
		item_typed      = 1'b0;
		item_res        = '0;
		errors          = 0;
		idle_cycles     = 0;
		dst_stall       = 0;
		src_calm        = 1'b0;
		dst_calm        = 1'b0;
		sh_full_scale   = 17'd65535;
		sh_lift         = '0;
		sh_gain         = 16'd16384;
		sh_gamma        = 13'd1000;
		sh_enhanced     = 1'b0;

		// square-root table from one half
		root = 64'd1 << 29;
		half_roots[0] = root;
		for (int k = 1; k <= 16; k++) begin
			root = int_sqrt(root << 30);
			half_roots[k] = root;
		end

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE) @(posedge clk);

		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].is_cfg)
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			else
				send_pixel(DIRECTED[i].pix, DIRECTED[i].typed, DIRECTED[i].res);
		end

		// random phases: new settings, then a burst of pixels
		sent = 0;
		while (sent < RAND_ITEMS) begin
			write_reg(lggc_pkg::CFG_FULL_SCALE, rand_full_scale());
			write_reg(lggc_pkg::CFG_LIFT, rand_lift());
			write_reg(lggc_pkg::CFG_GAIN, rand_gain());
			write_reg(lggc_pkg::CFG_GAMMA, rand_gamma());
			// enhanced mode most of the time, it has the most behavior
			write_reg(lggc_pkg::CFG_ENHANCED, 17'($urandom_range(0, 3) != 0));
			src_calm = ($urandom_range(0, 3) == 0);
			dst_calm = ($urandom_range(0, 3) == 0);
			burst = $urandom_range(60, 160);
			repeat (burst) send_pixel(rand_pixel(), 1'b0, NO_RES);
			sent += burst;
		end
		src.valid <= 1'b0;
		@(posedge clk);

		wait (pending_results.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
